@@ rtl/unsorted_list_table_unit_assert.svh @@
// Assertion macros used by the list table RTL.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef UNSORTED_LIST_TABLE_UNIT_ASSERT_SVH
`define UNSORTED_LIST_TABLE_UNIT_ASSERT_SVH

// Same-cycle implication, checked while out of reset.
`define ULT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked while out of reset.
`define ULT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/ult_pkg.sv @@
package ult_pkg;

  // Table geometry.
  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int DATA_W   = 32;
  localparam int FUNC_W   = 3;
  localparam int STAT_W   = 2;

  // Operation codes carried by an input word.
  typedef enum logic [FUNC_W-1:0] {
    FN_APPEND    = 3'd0,
    FN_DELETE    = 3'd1,
    FN_FIND      = 3'd2,
    FN_NEXT      = 3'd3,
    FN_RESET_CUR = 3'd4,
    FN_CLEAR     = 3'd5
  } func_e;

  // Result status codes.
  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_NO_NEXT   = 2'd3
  } status_e;

  // Control sequencer states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_NEXT
  } state_e;

  // One write and one read request to the entry store.
  typedef struct packed {
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [DATA_W-1:0] wr_data;
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
  } ram_req_t;

endpackage

@@ rtl/unsorted_list_table_unit.sv @@
// Unsorted list table: a fixed-capacity list of signed 32-bit entries with a
// forward cursor. Each input word carries an operation code and a value; each
// one produces exactly one result word with status, data, position and count.
// Both channels use valid and stall; a word moves when valid is high and stall
// is low. Results sit in an output register, and a new input word is taken
// only while that register is empty or its word leaves in the same cycle.
// Path from accept to result valid, for a list of n entries:
//   append, reset cursor, clear and unused codes: result registered at accept.
//   next: one read of the entry store, or none when there is no next entry.
//   find: a scan of the entries up to the match, or all n when the value is absent.
//   delete: as find, then a shift down of the entries after the match.
// Only one word is in work at a time; the next word can be taken in the cycle
// after the result is loaded. The scan and the shift each move one entry per
// cycle through the single read port of the entry store, so a delete in a
// full list of 64 entries holds the input side while it reads all of them.
// Reset empties the list and puts the cursor before the first entry; the
// store itself is not cleared. While the receiver stalls a waiting result,
// the input side stalls as well.
`include "unsorted_list_table_unit_assert.svh"

module unsorted_list_table_unit
  import ult_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [FUNC_W-1:0]        func_i,
  input  logic signed [DATA_W-1:0] value_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [STAT_W-1:0]        status_o,
  output logic signed [DATA_W-1:0] data_o,
  output logic [IDX_W-1:0]         position_o,
  output logic [CNT_W-1:0]         count_o
);

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [CNT_W-1:0]  cursor_q, cursor_d;
  logic [CNT_W-1:0]  issue_q, issue_d;
  logic              pend_q, pend_d;
  logic [IDX_W-1:0]  pend_idx_q, pend_idx_d;
  logic [DATA_W-1:0] value_q, value_d;
  logic              del_q, del_d;
  logic              out_valid_q;
  logic [STAT_W-1:0] status_q;
  logic [DATA_W-1:0] data_q;
  logic [IDX_W-1:0]  position_q;
  logic [CNT_W-1:0]  count_res_q;

  logic              in_acc;
  logic              out_free;
  func_e             fn;
  logic [CNT_W-1:0]  nxt_cur;
  logic              next_ok;
  logic              hit;
  logic              walk_end;
  logic              out_load;
  status_e           res_status;
  logic [DATA_W-1:0] res_data;
  logic [IDX_W-1:0]  res_pos;
  ram_req_t          ram_req;
  logic [DATA_W-1:0] rd_data;

  // Entry store.
  ult_store u_store (
    .clk_i     (clk_i),
    .req_i     (ram_req),
    .rd_data_o (rd_data)
  );

  // Handshake and shared conditions.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE) || !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign fn         = func_e'(func_i);
  assign nxt_cur    = cursor_q + CNT_W'(1);
  assign next_ok    = (count_q != '0) && (nxt_cur < count_q);
  assign hit        = pend_q && (rd_data == value_q);
  assign walk_end   = (issue_q >= count_q);

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if ((fn == FN_DELETE) || (fn == FN_FIND)) begin
            state_d = S_SCAN;
          end else if ((fn == FN_NEXT) && next_ok) begin
            state_d = S_NEXT;
          end
        end
      end
      S_SCAN: begin
        if (hit) begin
          state_d = del_q ? S_SHIFT : S_IDLE;
        end else if (walk_end) begin
          state_d = S_IDLE;
        end
      end
      S_SHIFT: begin
        if (walk_end) begin
          state_d = S_IDLE;
        end
      end
      S_NEXT: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Datapath, store requests and result loading.
  always_comb begin
    count_d    = count_q;
    cursor_d   = cursor_q;
    issue_d    = issue_q;
    pend_d     = pend_q;
    pend_idx_d = pend_idx_q;
    value_d    = value_q;
    del_d      = del_q;
    ram_req    = '0;
    out_load   = 1'b0;
    res_status = ST_OK;
    res_data   = '0;
    res_pos    = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          unique case (fn)
            FN_APPEND: begin
              out_load = 1'b1;
              if (count_q < CNT_W'(CAPACITY)) begin
                ram_req.wr_en   = 1'b1;
                ram_req.wr_addr = count_q[IDX_W-1:0];
                ram_req.wr_data = value_i;
                count_d         = count_q + CNT_W'(1);
              end else begin
                res_status = ST_FULL;
              end
            end
            FN_DELETE, FN_FIND: begin
              value_d = value_i;
              del_d   = (fn == FN_DELETE);
              issue_d = '0;
              pend_d  = 1'b0;
            end
            FN_NEXT: begin
              if (next_ok) begin
                ram_req.rd_en   = 1'b1;
                ram_req.rd_addr = nxt_cur[IDX_W-1:0];
                cursor_d        = nxt_cur;
              end else begin
                out_load   = 1'b1;
                res_status = ST_NO_NEXT;
              end
            end
            FN_RESET_CUR: begin
              cursor_d = '1;
              out_load = 1'b1;
            end
            FN_CLEAR: begin
              count_d  = '0;
              out_load = 1'b1;
            end
            default: begin
              out_load = 1'b1;
            end
          endcase
        end
      end
      S_SCAN: begin
        // Check the word read last cycle; on no match, read on until the end.
        if (hit) begin
          pend_d = 1'b0;
          if (del_q) begin
            issue_d = CNT_W'(pend_idx_q) + CNT_W'(1);
          end else begin
            out_load = 1'b1;
            res_pos  = pend_idx_q;
          end
        end else if (walk_end) begin
          pend_d     = 1'b0;
          out_load   = 1'b1;
          res_status = ST_NOT_FOUND;
        end else begin
          ram_req.rd_en   = 1'b1;
          ram_req.rd_addr = issue_q[IDX_W-1:0];
          pend_d          = 1'b1;
          pend_idx_d      = issue_q[IDX_W-1:0];
          issue_d         = issue_q + CNT_W'(1);
        end
      end
      S_SHIFT: begin
        // Each entry read last cycle is written one place lower.
        if (pend_q) begin
          ram_req.wr_en   = 1'b1;
          ram_req.wr_addr = pend_idx_q - IDX_W'(1);
          ram_req.wr_data = rd_data;
        end
        if (walk_end) begin
          pend_d   = 1'b0;
          count_d  = count_q - CNT_W'(1);
          out_load = 1'b1;
        end else begin
          ram_req.rd_en   = 1'b1;
          ram_req.rd_addr = issue_q[IDX_W-1:0];
          pend_d          = 1'b1;
          pend_idx_d      = issue_q[IDX_W-1:0];
          issue_d         = issue_q + CNT_W'(1);
        end
      end
      S_NEXT: begin
        out_load = 1'b1;
        res_data = rd_data;
      end
      default: begin
        out_load = 1'b0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      cursor_q    <= '1;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      cursor_q <= cursor_d;
      pend_q   <= pend_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    issue_q    <= issue_d;
    pend_idx_q <= pend_idx_d;
    value_q    <= value_d;
    del_q      <= del_d;
    if (out_load) begin
      status_q    <= res_status;
      data_q      <= res_data;
      position_q  <= res_pos;
      count_res_q <= count_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign data_o      = data_q;
  assign position_o  = position_q;
  assign count_o     = count_res_q;

  // Checks on the sequencer and the result register.
  `ULT_ASSERT_NOW(a_count_range, 1'b1, count_q <= CNT_W'(CAPACITY),
    "entry count exceeds capacity")
  `ULT_ASSERT_NOW(a_busy_stalls, state_q != S_IDLE, in_stall_o,
    "input word accepted while an operation is in work")
  `ULT_ASSERT_NOW(a_load_free, out_load, out_free,
    "result register overwritten before it was taken")
  `ULT_ASSERT_NEXT(a_next_returns, (state_q == S_NEXT), out_valid_q && (state_q == S_IDLE),
    "next operation did not deliver its result")

endmodule

@@ rtl/ult_store.sv @@
module ult_store
  import ult_pkg::*;
(
  input  logic              clk_i,
  input  ram_req_t          req_i,
  output logic [DATA_W-1:0] rd_data_o
);

  logic [DATA_W-1:0] mem [CAPACITY];
  logic [DATA_W-1:0] rd_data_q;

  // Simple dual-port array: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_data_q <= mem[req_i.rd_addr];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ tb/unsorted_list_table_checker.sv @@
`timescale 1ns / 100ps

// Watches both channels of the list table, predicts each result word from its
// own copy of the list and compares what the block returns, oldest first.
module unsorted_list_table_checker
  import ult_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  logic                     in_stall_i,
  input  logic [FUNC_W-1:0]        func_i,
  input  logic signed [DATA_W-1:0] value_i,
  input  logic                     out_valid_i,
  input  logic                     out_stall_i,
  input  logic [STAT_W-1:0]        status_i,
  input  logic signed [DATA_W-1:0] data_i,
  input  logic [IDX_W-1:0]         position_i,
  input  logic [CNT_W-1:0]         count_i,
  output int                       fail_cnt_o,
  output int                       pending_cnt_o,
  output int                       result_cnt_o,
  output int                       full_cnt_o,
  output int                       miss_cnt_o,
  output int                       no_next_cnt_o
);

  // One result word as the block should return it.
  typedef struct packed {
    status_e           status;
    logic [DATA_W-1:0] data;
    logic [IDX_W-1:0]  position;
    logic [CNT_W-1:0]  count;
  } list_result_t;

  // Shadow copy of the list contents, its length and the iterator.
  logic [DATA_W-1:0] shadow_entries [CAPACITY];
  int                shadow_len;
  int                shadow_cursor;
  list_result_t      awaited_results [$];

  // Applies one operation to the shadow list and returns the result it gives.
  function automatic list_result_t apply_list_op(logic [FUNC_W-1:0] fn,
                                                 logic [DATA_W-1:0] val);
    list_result_t res;
    int           hit;
    int           i;
    res = '{status: ST_OK, data: '0, position: '0, count: '0};
    hit = -1;
    for (i = 0; i < shadow_len; i++) begin
      if (hit < 0 && shadow_entries[i] == val) begin
        hit = i;
      end
    end
    case (fn)
      FN_APPEND: begin
        if (shadow_len < CAPACITY) begin
          shadow_entries[shadow_len] = val;
          shadow_len++;
        end else begin
          res.status = ST_FULL;
        end
      end
      FN_DELETE: begin
        if (hit < 0) begin
          res.status = ST_NOT_FOUND;
        end else begin
          // Close the gap left by the removed entry.
          for (i = hit; i + 1 < shadow_len; i++) begin
            shadow_entries[i] = shadow_entries[i + 1];
          end
          shadow_len--;
        end
      end
      FN_FIND: begin
        if (hit < 0) begin
          res.status = ST_NOT_FOUND;
        end else begin
          res.position = IDX_W'(hit);
        end
      end
      FN_NEXT: begin
        // The cursor may sit past the end after a delete or a clear.
        if (shadow_len != 0 && shadow_cursor + 1 < shadow_len) begin
          shadow_cursor++;
          res.data = shadow_entries[shadow_cursor];
        end else begin
          res.status = ST_NO_NEXT;
        end
      end
      FN_RESET_CUR: begin
        shadow_cursor = -1;
      end
      FN_CLEAR: begin
        shadow_len = 0;
      end
      default: begin
      end
    endcase
    res.count = CNT_W'(shadow_len);
    return res;
  endfunction

  // Compare every accepted result word, then predict every accepted input word.
  always @(posedge clk_i or negedge rst_ni) begin
    list_result_t want;
    if (!rst_ni) begin
      shadow_len    = 0;
      shadow_cursor = -1;
      awaited_results.delete();
      fail_cnt_o    = 0;
      pending_cnt_o = 0;
      result_cnt_o  = 0;
      full_cnt_o    = 0;
      miss_cnt_o    = 0;
      no_next_cnt_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        result_cnt_o++;
        if (status_i == ST_FULL) full_cnt_o++;
        if (status_i == ST_NOT_FOUND) miss_cnt_o++;
        if (status_i == ST_NO_NEXT) no_next_cnt_o++;
        if (awaited_results.size() == 0) begin
          $error("result word with none awaited: status %0d count %0d", status_i, count_i);
          fail_cnt_o++;
        end else begin
          want = awaited_results.pop_front();
          if (status_i !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, status_i);
            fail_cnt_o++;
          end
          if (data_i !== want.data) begin
            $error("data: expected %0d, actual %0d", $signed(want.data), data_i);
            fail_cnt_o++;
          end
          if (position_i !== want.position) begin
            $error("position: expected %0d, actual %0d", want.position, position_i);
            fail_cnt_o++;
          end
          if (count_i !== want.count) begin
            $error("count: expected %0d, actual %0d", want.count, count_i);
            fail_cnt_o++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        awaited_results.push_back(apply_list_op(func_i, value_i));
      end
      pending_cnt_o = awaited_results.size();
    end
  end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
  import ult_pkg::*;

  // Codes outside the defined operations; the block must leave the list unchanged and return an OK result.
  localparam logic [FUNC_W-1:0] FN_SPARE_6 = 3'd6;
  localparam logic [FUNC_W-1:0] FN_SPARE_7 = 3'd7;
  localparam int                IDLE_PCT   = 28;
  localparam logic [DATA_W-1:0] FILL_TAG   = 32'hA5A5_0000;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     in_valid_i;
  logic                     in_stall_o;
  logic [FUNC_W-1:0]        func_i;
  logic signed [DATA_W-1:0] value_i;
  logic                     out_valid_o;
  logic                     out_stall_i;
  logic [STAT_W-1:0]        status_o;
  logic signed [DATA_W-1:0] data_o;
  logic [IDX_W-1:0]         position_o;
  logic [CNT_W-1:0]         count_o;

  int fail_cnt;
  int pending_cnt;
  int result_cnt;
  int full_cnt;
  int miss_cnt;
  int no_next_cnt;
  int words_sent;
  bit calm;

  unsorted_list_table_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .func_i      (func_i),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_o    (status_o),
    .data_o      (data_o),
    .position_o  (position_o),
    .count_o     (count_o)
  );

  unsorted_list_table_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_i    (in_stall_o),
    .func_i        (func_i),
    .value_i       (value_i),
    .out_valid_i   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_i      (status_o),
    .data_i        (data_o),
    .position_i    (position_o),
    .count_i       (count_o),
    .fail_cnt_o    (fail_cnt),
    .pending_cnt_o (pending_cnt),
    .result_cnt_o  (result_cnt),
    .full_cnt_o    (full_cnt),
    .miss_cnt_o    (miss_cnt),
    .no_next_cnt_o (no_next_cnt)
  );

  // Free-running clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // The receiver stalls at random except during calm stretches.
  always @(negedge clk_i) begin
    out_stall_i <= !calm && ($urandom_range(99) < IDLE_PCT);
  end

  // Hard stop in case the block hangs.
  initial begin
    #5_000_000;
    $display("tb_top NOT OK");
    $finish;
  end

  // Offers one word after an optional random gap and holds it until accepted.
  task automatic send_word(input logic [FUNC_W-1:0] fn, input logic [DATA_W-1:0] val);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    func_i     = fn;
    value_i    = val;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
    words_sent++;
  endtask

  // Holds the input side until every predicted result has come back.
  task automatic drain_results();
    in_valid_i = 1'b0;
    while (pending_cnt != 0) @(negedge clk_i);
  endtask

  // Values mostly from a small pool so that finds and deletes often hit.
  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(9))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'hFFFF_FFFF;
      3, 4:    return $urandom;
      default: return DATA_W'($urandom_range(5));
    endcase
  endfunction

  initial begin
    int i;
    int n;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    func_i      = FN_APPEND;
    value_i     = '0;
    out_stall_i = 1'b0;
    calm        = 1'b0;
    words_sent  = 0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: empty list, extremes, iteration, first-match delete, spare codes.
    send_word(FN_NEXT, 32'd0);
    send_word(FN_FIND, 32'd5);
    send_word(FN_DELETE, 32'd5);
    send_word(FN_APPEND, 32'h8000_0000);
    send_word(FN_APPEND, 32'h7FFF_FFFF);
    send_word(FN_APPEND, 32'd0);
    send_word(FN_APPEND, 32'hFFFF_FFFF);
    send_word(FN_APPEND, 32'h5555_5555);
    send_word(FN_APPEND, 32'hAAAA_AAAA);
    send_word(FN_FIND, 32'h7FFF_FFFF);
    send_word(FN_FIND, 32'hAAAA_AAAA);
    send_word(FN_NEXT, 32'd0);
    send_word(FN_NEXT, 32'd0);
    send_word(FN_RESET_CUR, 32'd0);
    send_word(FN_NEXT, 32'd0);
    send_word(FN_DELETE, 32'h8000_0000);
    send_word(FN_FIND, 32'h7FFF_FFFF);
    send_word(FN_SPARE_6, 32'hFFFF_FFFF);
    send_word(FN_SPARE_7, 32'd0);
    send_word(FN_APPEND, 32'd0);
    send_word(FN_DELETE, 32'd0);
    send_word(FN_NEXT, 32'd0);
    send_word(FN_CLEAR, 32'd0);
    send_word(FN_NEXT, 32'd0);
    send_word(FN_FIND, 32'hFFFF_FFFF);
    drain_results();

    // Fill to capacity with distinct values, without any idling, then walk it.
    calm = 1'b1;
    for (i = 0; i < CAPACITY; i++) send_word(FN_APPEND, FILL_TAG ^ DATA_W'(i));
    send_word(FN_APPEND, 32'd1);
    send_word(FN_FIND, FILL_TAG ^ DATA_W'(CAPACITY - 1));
    send_word(FN_RESET_CUR, 32'd0);
    for (i = 0; i < CAPACITY + 1; i++) send_word(FN_NEXT, 32'd0);
    calm = 1'b0;
    send_word(FN_DELETE, FILL_TAG);
    send_word(FN_FIND, FILL_TAG ^ DATA_W'(CAPACITY - 1));
    send_word(FN_NEXT, 32'd0);
    send_word(FN_CLEAR, 32'd0);

    // Random scenarios built from well-formed sequences plus some noise.
    while (words_sent < 425) begin
      case ($urandom_range(9))
        0, 1: begin
          n = $urandom_range(10, 70);
          for (i = 0; i < n; i++) send_word(FN_APPEND, pick_value());
        end
        2, 3: begin
          send_word(FN_RESET_CUR, $urandom);
          n = $urandom_range(3, 20);
          for (i = 0; i < n; i++) send_word(FN_NEXT, $urandom);
        end
        4, 5, 6: begin
          for (i = 0; i < 8; i++) begin
            send_word($urandom_range(1) ? FN_FIND : FN_DELETE, pick_value());
          end
        end
        7: begin
          for (i = 0; i < 6; i++) send_word(FUNC_W'($urandom_range(7)), $urandom);
        end
        8: begin
          send_word(FN_CLEAR, $urandom);
          n = $urandom_range(1, 6);
          for (i = 0; i < n; i++) send_word(FN_APPEND, pick_value());
        end
        default: begin
          drain_results();
        end
      endcase
    end

    // Wait for the last results and let the block settle.
    in_valid_i = 1'b0;
    while (pending_cnt != 0) @(negedge clk_i);
    repeat (80) @(posedge clk_i);

    $display("Sent %0d words to the list table and checked %0d result words.",
             words_sent, result_cnt);
    $display("Statuses seen: %0d full, %0d not found, %0d no next.",
             full_cnt, miss_cnt, no_next_cnt);
    if (fail_cnt == 0 && pending_cnt == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/ult_pkg.sv
rtl/ult_store.sv
rtl/unsorted_list_table_unit.sv
tb/unsorted_list_table_checker.sv
tb/tb_top.sv
